// ----- rtl/cftr_pkg.sv -----
package cftr_pkg;

   localparam int DefaultMaxPayload = 64;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_VALUE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LONG_ID      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SHORT_ID     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LONG_LENGTH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SHORT_LENGTH = 3'd4;

   // Register values after reset.
   localparam logic [7:0] RESET_HEADER_VALUE = 8'hFE;
   localparam logic [7:0] RESET_LONG_ID      = 8'hCA;
   localparam logic [7:0] RESET_SHORT_ID     = 8'hCB;
   localparam logic [6:0] RESET_LONG_LENGTH  = 7'd36;
   localparam logic [6:0] RESET_SHORT_LENGTH = 7'd24;

   // Event codes on the response channel.
   localparam logic [1:0] EV_START   = 2'd0;
   localparam logic [1:0] EV_PAYLOAD = 2'd1;
   localparam logic [1:0] EV_END     = 2'd2;

   localparam logic FRAME_LONG  = 1'b0;
   localparam logic FRAME_SHORT = 1'b1;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h8408;

   typedef struct packed {
      logic [7:0] header_value;
      logic [7:0] long_id;
      logic [7:0] short_id;
      logic [6:0] long_length;
      logic [6:0] short_length;
   } cftr_cfg_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic        frame_kind;
      logic [5:0]  byte_index;
      logic [7:0]  payload_byte;
      logic        crc_ok;
      logic [15:0] computed_crc;
   } cftr_result_type;

endpackage

// ----- rtl/cftr_if.sv -----
interface cftr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface cftr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic        frame_kind;
   logic [5:0]  byte_index;
   logic [7:0]  payload_byte;
   logic        crc_ok;
   logic [15:0] computed_crc;

   modport source (output valid, output event_kind, output frame_kind, output byte_index,
                   output payload_byte, output crc_ok, output computed_crc, input ready);
   modport sink (input valid, input event_kind, input frame_kind, input byte_index,
                 input payload_byte, input crc_ok, input computed_crc, output ready);
endinterface

interface cftr_csr_if import cftr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/crc16_framed_telemetry_receiver_core.sv -----
// Framed telemetry receiver with a reflected CRC-16 check.
//
// Bytes from the serial link arrive on the request channel (req_bus), one
// byte per request. Configuration registers (header byte, the two frame IDs
// and the two payload lengths) are written through csr_bus, which is always
// ready; write them only while no frame bytes are in flight.
// Events leave on rsp_bus: frame start on the ID byte, one event per payload
// byte with its index, and frame end on the second CRC byte with the verdict.
// Header, rejected ID and CRC low bytes produce no event.
//
// A request is held in an input register and processed once the result
// register is free, which registers its event in the result register.
// While rsp_bus does not stall, one byte is taken every cycle; the limit
// is the combinational CRC update between the input register and the
// result register. When rsp_bus stalls, the result register holds its
// event and one more request is still taken into the input register
// before req_bus.ready drops.
// Synchronous reset restores the register defaults, empties both pipeline
// registers and returns the receiver to hunting for a header byte.
module crc16_framed_telemetry_receiver_core
   import cftr_pkg::*;
#(
   parameter int MAX_PAYLOAD = DefaultMaxPayload
) (
   input logic       clock,
   input logic       reset,
   cftr_req_if.sink  req_bus,
   cftr_rsp_if.source rsp_bus,
   cftr_csr_if.sink  csr_bus
);

   cftr_cfg_type    cfg_ff, cfg_in;
   logic            s1_valid_ff, s1_valid_in;
   logic [7:0]      s1_byte_ff, s1_byte_in;
   logic            rsp_valid_ff, rsp_valid_in;
   cftr_result_type rsp_data_ff, rsp_data_in;

   logic            out_free;
   logic            step;
   logic            res_valid;
   cftr_result_type res;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign step          = s1_valid_ff && out_free;
   assign req_bus.ready = !s1_valid_ff || out_free;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_HEADER_VALUE: cfg_in.header_value = csr_bus.data;
            REG_LONG_ID:      cfg_in.long_id      = csr_bus.data;
            REG_SHORT_ID:     cfg_in.short_id     = csr_bus.data;
            REG_LONG_LENGTH:  cfg_in.long_length  = csr_bus.data[6:0];
            REG_SHORT_LENGTH: cfg_in.short_length = csr_bus.data[6:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (req_bus.ready) begin
         s1_valid_in = req_bus.valid;
         s1_byte_in  = req_bus.rx_byte;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = step && res_valid;
         rsp_data_in  = res;
      end
   end

   cftr_frame_fsm #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (s1_byte_ff),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_value <= RESET_HEADER_VALUE;
         cfg_ff.long_id      <= RESET_LONG_ID;
         cfg_ff.short_id     <= RESET_SHORT_ID;
         cfg_ff.long_length  <= RESET_LONG_LENGTH;
         cfg_ff.short_length <= RESET_SHORT_LENGTH;
         s1_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_byte_ff  <= s1_byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.event_kind   = rsp_data_ff.event_kind;
   assign rsp_bus.frame_kind   = rsp_data_ff.frame_kind;
   assign rsp_bus.byte_index   = rsp_data_ff.byte_index;
   assign rsp_bus.payload_byte = rsp_data_ff.payload_byte;
   assign rsp_bus.crc_ok       = rsp_data_ff.crc_ok;
   assign rsp_bus.computed_crc = rsp_data_ff.computed_crc;

endmodule

// ----- rtl/cftr_frame_fsm.sv -----
module cftr_frame_fsm
   import cftr_pkg::*;
#(
   parameter int MAX_PAYLOAD = DefaultMaxPayload
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      rx_byte,
   input  cftr_cfg_type    cfg,
   output logic            res_valid,
   output cftr_result_type res
);

   localparam int CNT_W = $clog2(MAX_PAYLOAD);
   localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_ID,
      PH_DATA,
      PH_CRC
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             frame_type_ff, frame_type_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       crc_low_ff, crc_low_in;

   logic [7:0]  len_raw;
   logic [7:0]  len;
   logic [7:0]  count_ext;
   logic [7:0]  count_inc;
   logic [15:0] crc_seed;
   logic [15:0] crc_next;

   // Reflected CRC-16 over one byte, one shift per bit.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   always_comb begin
      len_raw = {1'b0, (frame_type_ff == FRAME_SHORT) ? cfg.short_length : cfg.long_length};
      if (len_raw == 8'd0) begin
         len = 8'd1;
      end else if (len_raw > MaxLen) begin
         len = MaxLen;
      end else begin
         len = len_raw;
      end
   end

   assign count_ext = 8'(count_ff);
   assign count_inc = count_ext + 8'd1;
   assign crc_seed  = (phase_ff == PH_HUNT) ? CRC_INIT : crc_ff;
   assign crc_next  = crc_byte(crc_seed, rx_byte);

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      frame_type_in = frame_type_ff;
      crc_in        = crc_ff;
      crc_low_in    = crc_low_ff;
      res_valid     = 1'b0;
      res           = '0;
      res.frame_kind = frame_type_ff;

      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == cfg.header_value) begin
               crc_in   = crc_next;
               count_in = '0;
               phase_in = PH_ID;
            end
         end
         PH_ID: begin
            if (rx_byte == cfg.short_id || rx_byte == cfg.long_id) begin
               // The short type wins when both IDs match.
               frame_type_in  = (rx_byte == cfg.short_id) ? FRAME_SHORT : FRAME_LONG;
               crc_in         = crc_next;
               count_in       = '0;
               phase_in       = PH_DATA;
               res_valid      = 1'b1;
               res.event_kind = EV_START;
               res.frame_kind = frame_type_in;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_DATA: begin
            if (count_ext < len) begin
               crc_in = crc_next;
               if (count_inc >= len) begin
                  count_in = '0;
                  phase_in = PH_CRC;
               end else begin
                  count_in = CNT_W'(count_inc);
               end
               res_valid        = 1'b1;
               res.event_kind   = EV_PAYLOAD;
               res.byte_index   = count_ext[5:0];
               res.payload_byte = rx_byte;
            end else begin
               // The length was lowered under the count: this is the CRC low byte.
               crc_low_in = rx_byte;
               count_in   = CNT_W'(1);
               phase_in   = PH_CRC;
            end
         end
         PH_CRC: begin
            if (count_ff == '0) begin
               crc_low_in = rx_byte;
               count_in   = CNT_W'(1);
            end else begin
               res_valid        = 1'b1;
               res.event_kind   = EV_END;
               res.crc_ok       = ({rx_byte, crc_low_ff} == crc_ff);
               res.computed_crc = crc_ff;
               phase_in         = PH_HUNT;
               count_in         = '0;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         count_ff      <= '0;
         frame_type_ff <= FRAME_LONG;
         crc_ff        <= CRC_INIT;
         crc_low_ff    <= 8'h00;
      end else if (step) begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         frame_type_ff <= frame_type_in;
         crc_ff        <= crc_in;
         crc_low_ff    <= crc_low_in;
      end
   end

endmodule

// ----- rtl/cftr_checker.sv -----
module cftr_checker
   import cftr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  event_kind,
   input logic        frame_kind,
   input logic [5:0]  byte_index,
   input logic [7:0]  payload_byte,
   input logic        crc_ok,
   input logic [15:0] computed_crc
);

   // A stalled event keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(event_kind) && $stable(frame_kind)
         && $stable(byte_index) && $stable(payload_byte) && $stable(crc_ok)
         && $stable(computed_crc))
      else $error("response changed while stalled");

   a_kind_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (event_kind == EV_START || event_kind == EV_PAYLOAD
         || event_kind == EV_END))
      else $error("unknown event kind");

   // Only the frame end event carries a CRC verdict.
   a_crc_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && event_kind != EV_END |-> !crc_ok && computed_crc == 16'h0000)
      else $error("CRC fields set outside frame end");

   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && event_kind != EV_PAYLOAD |-> byte_index == 6'd0 && payload_byte == 8'd0)
      else $error("payload fields set outside payload event");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind crc16_framed_telemetry_receiver_core cftr_checker u_cftr_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .event_kind   (rsp_bus.event_kind),
   .frame_kind   (rsp_bus.frame_kind),
   .byte_index   (rsp_bus.byte_index),
   .payload_byte (rsp_bus.payload_byte),
   .crc_ok       (rsp_bus.crc_ok),
   .computed_crc (rsp_bus.computed_crc)
);

// ----- tb/tb_crc16_framed_telemetry_receiver_core.sv -----
`timescale 1ns / 100ps

module tb_crc16_framed_telemetry_receiver_core;
   import cftr_pkg::*;

   localparam int RANDOM_ITEMS  = 1650;
   localparam int PHASE_ITEMS   = 200;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO = REG_SHORT_LENGTH + 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI = '1;

   localparam cftr_result_type NO_EVENT = '0;

   typedef enum logic [1:0] {RX_HUNT, RX_ID, RX_PAYLOAD, RX_CRC} rx_phase_type;
   typedef enum {CHK_MODEL, CHK_QUIET, CHK_TYPED} check_type;
   typedef enum {OP_BYTE, OP_CRC_LO, OP_CRC_HI, OP_CSR} plan_op_type;

   typedef struct {
      plan_op_type            op;
      logic [CSR_INDEX_W-1:0] index;
      logic [7:0]             value;
      check_type              chk;
      cftr_result_type        ev;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cftr_req_if req_bus ();
   cftr_rsp_if rsp_bus ();
   cftr_csr_if csr_bus ();

   crc16_framed_telemetry_receiver_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror of the receiver state and its registers.
   cftr_cfg_type rx_cfg;
   rx_phase_type rx_phase;
   logic [6:0]   rx_count;
   logic         rx_type;
   logic [15:0]  rx_crc;
   logic [7:0]   rx_crc_low;

   cftr_result_type pending_events[$];
   plan_row_type    plan[$];

   int fails = 0;
   int items_sent = 0;
   bit no_idle = 1'b0;
   bit hold_go = 1'b0;
   bit rsp_hold = 1'b0;

   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   function automatic logic [6:0] frame_length();
      logic [6:0] n;
      n = (rx_type == FRAME_SHORT) ? rx_cfg.short_length : rx_cfg.long_length;
      if (n < 7'd1) n = 7'd1;
      if (n > 7'(DefaultMaxPayload)) n = 7'(DefaultMaxPayload);
      return n;
   endfunction

   function automatic void reset_receiver_state();
      rx_cfg.header_value = RESET_HEADER_VALUE;
      rx_cfg.long_id      = RESET_LONG_ID;
      rx_cfg.short_id     = RESET_SHORT_ID;
      rx_cfg.long_length  = RESET_LONG_LENGTH;
      rx_cfg.short_length = RESET_SHORT_LENGTH;
      rx_phase   = RX_HUNT;
      rx_count   = '0;
      rx_type    = FRAME_LONG;
      rx_crc     = CRC_INIT;
      rx_crc_low = '0;
   endfunction

   // Advances the mirrored receiver by one byte; returns 1 when the byte yields an event.
   function automatic bit decode_byte(input logic [7:0] b, output cftr_result_type ev);
      bit has;
      ev  = NO_EVENT;
      has = 1'b0;
      case (rx_phase)
         RX_HUNT: begin
            if (b == rx_cfg.header_value) begin
               rx_crc   = crc16_update(CRC_INIT, b);
               rx_count = '0;
               rx_phase = RX_ID;
            end
         end
         RX_ID: begin
            if (b == rx_cfg.short_id || b == rx_cfg.long_id) begin
               rx_type       = (b == rx_cfg.short_id) ? FRAME_SHORT : FRAME_LONG;
               rx_crc        = crc16_update(rx_crc, b);
               rx_count      = '0;
               rx_phase      = RX_PAYLOAD;
               ev.event_kind = EV_START;
               ev.frame_kind = rx_type;
               has           = 1'b1;
            end else begin
               rx_phase = RX_HUNT;
            end
         end
         RX_PAYLOAD: begin
            if (rx_count < frame_length()) begin
               ev.event_kind   = EV_PAYLOAD;
               ev.frame_kind   = rx_type;
               ev.byte_index   = rx_count[5:0];
               ev.payload_byte = b;
               has             = 1'b1;
               rx_crc          = crc16_update(rx_crc, b);
               rx_count        = rx_count + 7'd1;
               if (rx_count >= frame_length()) begin
                  rx_count = '0;
                  rx_phase = RX_CRC;
               end
            end else begin
               // The length was lowered under the count, so this is the CRC low byte.
               rx_crc_low = b;
               rx_count   = 7'd1;
               rx_phase   = RX_CRC;
            end
         end
         default: begin
            if (rx_count == '0) begin
               rx_crc_low = b;
               rx_count   = 7'd1;
            end else begin
               ev.event_kind   = EV_END;
               ev.frame_kind   = rx_type;
               ev.crc_ok       = ({b, rx_crc_low} == rx_crc);
               ev.computed_crc = rx_crc;
               has             = 1'b1;
               rx_phase        = RX_HUNT;
               rx_count        = '0;
            end
         end
      endcase
      return has;
   endfunction

   function automatic cftr_result_type make_event(input logic [1:0] kind, input logic fk,
                                                  input logic [5:0] idx, input logic [7:0] pb);
      cftr_result_type ev;
      ev              = NO_EVENT;
      ev.event_kind   = kind;
      ev.frame_kind   = fk;
      ev.byte_index   = idx;
      ev.payload_byte = pb;
      return ev;
   endfunction

   function automatic void add_row(input plan_op_type op, input logic [CSR_INDEX_W-1:0] index,
                                   input logic [7:0] value, input check_type chk,
                                   input cftr_result_type ev);
      plan_row_type r;
      r.op    = op;
      r.index = index;
      r.value = value;
      r.chk   = chk;
      r.ev    = ev;
      plan.push_back(r);
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   function automatic logic [6:0] random_length();
      int r;
      r = $urandom_range(0, 19);
      if (r < 15) return 7'($urandom_range(1, 12));
      if (r < 19) return 7'($urandom_range(13, 64));
      return ($urandom_range(0, 1) != 0) ? 7'd0 : 7'($urandom_range(65, 127));
   endfunction

   function automatic logic [6:0] extreme_length();
      case ($urandom_range(0, 3))
         0: return 7'd0;
         1: return 7'd1;
         2: return 7'(DefaultMaxPayload);
         default: return 7'd127;
      endcase
   endfunction

   function automatic logic [7:0] extreme_byte();
      return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
   endfunction

   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fails++;
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input check_type chk,
                            input cftr_result_type typed_ev);
      int gap;
      bit has;
      cftr_result_type ev;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      has = decode_byte(b, ev);
      if (chk == CHK_TYPED) pending_events.push_back(typed_ev);
      else if (chk == CHK_MODEL && has) pending_events.push_back(ev);
      items_sent++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         REG_HEADER_VALUE: rx_cfg.header_value = value;
         REG_LONG_ID:      rx_cfg.long_id      = value;
         REG_SHORT_ID:     rx_cfg.short_id     = value;
         REG_LONG_LENGTH:  rx_cfg.long_length  = value[6:0];
         REG_SHORT_LENGTH: rx_cfg.short_length = value[6:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Stops requests and lets every expected event, and any byte still in the pipe, drain.
   task automatic wait_all_events();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic setup_random(input bit extreme);
      logic [7:0] hdr;
      logic [7:0] lid;
      logic [7:0] sid;
      logic [6:0] llen;
      logic [6:0] slen;
      if (extreme) begin
         hdr  = extreme_byte();
         lid  = extreme_byte();
         sid  = extreme_byte();
         llen = extreme_length();
         slen = extreme_length();
      end else begin
         hdr  = rand_byte();
         lid  = rand_byte();
         sid  = ($urandom_range(0, 7) == 0) ? lid : rand_byte();
         llen = random_length();
         slen = random_length();
      end
      write_csr(REG_HEADER_VALUE, hdr);
      write_csr(REG_LONG_ID, lid);
      write_csr(REG_SHORT_ID, sid);
      // Bit 7 of a length write is random; the register keeps only seven bits.
      write_csr(REG_LONG_LENGTH, (rand_byte() & 8'h80) | {1'b0, llen});
      write_csr(REG_SHORT_LENGTH, (rand_byte() & 8'h80) | {1'b0, slen});
      if ($urandom_range(0, 1) != 0)
         write_csr(REG_SHORT_LENGTH + CSR_INDEX_W'($urandom_range(1, 3)), rand_byte());
   endtask

   task automatic send_sequence();
      int r;
      logic [15:0] crc_word;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         send_byte(rx_cfg.header_value, CHK_MODEL, NO_EVENT);
         send_byte(($urandom_range(0, 1) != 0) ? rx_cfg.short_id : rx_cfg.long_id,
                   CHK_MODEL, NO_EVENT);
         // Now and then the frame is cut short and the next bytes land mid-frame.
         while (rx_phase == RX_PAYLOAD && $urandom_range(0, 199) != 0)
            send_byte(rand_byte(), CHK_MODEL, NO_EVENT);
         if (rx_phase == RX_CRC) begin
            crc_word = rx_crc;
            if ($urandom_range(0, 3) == 0) crc_word ^= 16'h1 << $urandom_range(0, 15);
            if (rx_count == '0) send_byte(crc_word[7:0], CHK_MODEL, NO_EVENT);
            if (rx_phase == RX_CRC) send_byte(crc_word[15:8], CHK_MODEL, NO_EVENT);
         end
      end else if (r < 90) begin
         repeat ($urandom_range(1, 3)) send_byte(rand_byte(), CHK_MODEL, NO_EVENT);
      end else begin
         send_byte(rx_cfg.header_value, CHK_MODEL, NO_EVENT);
         send_byte(rand_byte(), CHK_MODEL, NO_EVENT);
      end
   endtask

   function automatic void build_plan();
      // Reset settings: a stray byte, the header, then the short ID opens a frame.
      add_row(OP_BYTE, '0, 8'hFF, CHK_QUIET, NO_EVENT);
      add_row(OP_BYTE, '0, RESET_HEADER_VALUE, CHK_QUIET, NO_EVENT);
      add_row(OP_BYTE, '0, RESET_SHORT_ID, CHK_TYPED,
              make_event(EV_START, FRAME_SHORT, 6'd0, 8'h00));
      add_row(OP_CSR, REG_SHORT_LENGTH, 8'd2, CHK_MODEL, NO_EVENT);
      add_row(OP_BYTE, '0, 8'h00, CHK_TYPED, make_event(EV_PAYLOAD, FRAME_SHORT, 6'd0, 8'h00));
      add_row(OP_BYTE, '0, 8'hFF, CHK_TYPED, make_event(EV_PAYLOAD, FRAME_SHORT, 6'd1, 8'hFF));
      add_row(OP_BYTE, '0, 8'h12, CHK_QUIET, NO_EVENT);
      add_row(OP_BYTE, '0, 8'h34, CHK_MODEL, NO_EVENT);

      // With both IDs equal the short type wins.
      add_row(OP_CSR, REG_HEADER_VALUE, 8'h00, CHK_MODEL, NO_EVENT);
      add_row(OP_CSR, REG_LONG_ID, 8'hCA, CHK_MODEL, NO_EVENT);
      add_row(OP_CSR, REG_SHORT_ID, 8'hCA, CHK_MODEL, NO_EVENT);
      add_row(OP_CSR, REG_LONG_LENGTH, 8'd0, CHK_MODEL, NO_EVENT);
      add_row(OP_CSR, REG_SHORT_LENGTH, 8'd1, CHK_MODEL, NO_EVENT);
      add_row(OP_BYTE, '0, 8'h00, CHK_QUIET, NO_EVENT);
      add_row(OP_BYTE, '0, 8'hCA, CHK_TYPED, make_event(EV_START, FRAME_SHORT, 6'd0, 8'h00));
      add_row(OP_BYTE, '0, 8'h80, CHK_TYPED, make_event(EV_PAYLOAD, FRAME_SHORT, 6'd0, 8'h80));
      add_row(OP_CRC_LO, '0, 8'h00, CHK_MODEL, NO_EVENT);
      add_row(OP_CRC_HI, '0, 8'h00, CHK_MODEL, NO_EVENT);

      // A rejected ID is not taken as a new header, and a bare ID in the hunt is ignored.
      add_row(OP_BYTE, '0, 8'h00, CHK_QUIET, NO_EVENT);
      add_row(OP_BYTE, '0, 8'h00, CHK_QUIET, NO_EVENT);
      add_row(OP_BYTE, '0, 8'hCA, CHK_QUIET, NO_EVENT);

      // A long length of zero behaves as one byte.
      add_row(OP_CSR, REG_SHORT_ID, 8'hCB, CHK_MODEL, NO_EVENT);
      add_row(OP_BYTE, '0, 8'h00, CHK_QUIET, NO_EVENT);
      add_row(OP_BYTE, '0, 8'hCA, CHK_TYPED, make_event(EV_START, FRAME_LONG, 6'd0, 8'h00));
      add_row(OP_BYTE, '0, 8'h7F, CHK_TYPED, make_event(EV_PAYLOAD, FRAME_LONG, 6'd0, 8'h7F));
      add_row(OP_CRC_LO, '0, 8'h00, CHK_MODEL, NO_EVENT);
      add_row(OP_CRC_HI, '0, 8'h00, CHK_MODEL, NO_EVENT);

      // Lengths above the maximum are clipped; writes to spare indexes change nothing.
      add_row(OP_CSR, REG_HEADER_VALUE, 8'hFE, CHK_MODEL, NO_EVENT);
      add_row(OP_CSR, REG_LONG_ID, 8'h01, CHK_MODEL, NO_EVENT);
      add_row(OP_CSR, REG_SHORT_ID, 8'h02, CHK_MODEL, NO_EVENT);
      add_row(OP_CSR, REG_LONG_LENGTH, 8'hFF, CHK_MODEL, NO_EVENT);
      add_row(OP_CSR, REG_SHORT_LENGTH, 8'd65, CHK_MODEL, NO_EVENT);
      add_row(OP_CSR, REG_SPARE_LO, 8'h00, CHK_MODEL, NO_EVENT);
      add_row(OP_CSR, REG_SPARE_HI, 8'hFF, CHK_MODEL, NO_EVENT);
      add_row(OP_BYTE, '0, 8'hFE, CHK_QUIET, NO_EVENT);
      add_row(OP_BYTE, '0, 8'h01, CHK_TYPED, make_event(EV_START, FRAME_LONG, 6'd0, 8'h00));
      add_row(OP_BYTE, '0, 8'hAA, CHK_TYPED, make_event(EV_PAYLOAD, FRAME_LONG, 6'd0, 8'hAA));
      add_row(OP_BYTE, '0, 8'h55, CHK_TYPED, make_event(EV_PAYLOAD, FRAME_LONG, 6'd1, 8'h55));
      add_row(OP_BYTE, '0, 8'h3C, CHK_TYPED, make_event(EV_PAYLOAD, FRAME_LONG, 6'd2, 8'h3C));

      // Lowering the length under the count makes the next byte the CRC low byte.
      add_row(OP_CSR, REG_LONG_LENGTH, 8'd2, CHK_MODEL, NO_EVENT);
      add_row(OP_BYTE, '0, 8'h77, CHK_QUIET, NO_EVENT);
      add_row(OP_BYTE, '0, 8'h99, CHK_MODEL, NO_EVENT);
   endfunction

   initial begin : stimulus
      int p;
      int phase_start;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = '0;
      csr_bus.data    = '0;
      reset_receiver_state();
      build_plan();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         case (plan[i].op)
            OP_BYTE:   send_byte(plan[i].value, plan[i].chk, plan[i].ev);
            OP_CRC_LO: send_byte(rx_crc[7:0], CHK_MODEL, NO_EVENT);
            OP_CRC_HI: send_byte(rx_crc[15:8], CHK_MODEL, NO_EVENT);
            default: begin
               wait_all_events();
               write_csr(plan[i].index, plan[i].value);
            end
         endcase
      end

      items_sent = 0;
      for (p = 0; items_sent < RANDOM_ITEMS; p++) begin
         wait_all_events();
         setup_random(p % 4 == 0);
         no_idle = (p % 3 == 1);
         // Hold off the event side so the pipe fills while requests keep coming.
         if (p == 2) hold_go = 1'b1;
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS && items_sent < RANDOM_ITEMS)
            send_sequence();
      end
      no_idle = 1'b0;

      wait_all_events();
      if (fails == 0) begin
         $display("crc16_framed_telemetry_receiver_core: match");
      end else begin
         $display("crc16_framed_telemetry_receiver_core: mismatch");
      end
      $finish;
   end

   initial begin : hold_timer
      wait (hold_go);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   initial begin : event_sink
      int stall;
      cftr_result_type want;
      rsp_bus.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         stall = no_idle ? 0 : $urandom_range(0, 4);
         if (stall != 0 || rsp_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
            while (rsp_hold) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         if (pending_events.size() == 0) begin
            $error("event_kind: expected no event, got 0x%0h", rsp_bus.event_kind);
            fails++;
         end else begin
            want = pending_events.pop_front();
            check_field("event_kind", want.event_kind, rsp_bus.event_kind);
            check_field("frame_kind", want.frame_kind, rsp_bus.frame_kind);
            check_field("byte_index", want.byte_index, rsp_bus.byte_index);
            check_field("payload_byte", want.payload_byte, rsp_bus.payload_byte);
            check_field("crc_ok", want.crc_ok, rsp_bus.crc_ok);
            check_field("computed_crc", want.computed_crc, rsp_bus.computed_crc);
         end
      end
   end

   initial begin : watchdog
      #(5_000_000);
      $display("crc16_framed_telemetry_receiver_core: mismatch");
      $finish;
   end

endmodule
